// ===== rtl/hsfc_pkg.sv =====
// package: opcodes, field constants and conversion functions
package hsfc_pkg;

  typedef enum logic {
    OP_H2S = 1'b0,
    OP_S2H = 1'b1
  } op_t;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] operand_bits;
  } req_t;

  typedef struct packed {
    logic [31:0] result_bits;
  } res_t;

  localparam logic [15:0] HALF_QNAN = 16'h7e00;
  localparam logic [15:0] HALF_INF  = 16'h7c00;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic        s;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lz;
    logic [10:0] norm;
    logic [7:0]  bexp;
    logic [31:0] r;
    s   = h[15];
    ex  = h[14:10];
    man = h[9:0];
    lz  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) lz = 4'(9 - i);
    end
    norm = {1'b0, man} << (lz + 4'd1);
    bexp = 8'd112 - {4'd0, lz};
    if (ex == 5'd0) begin
      if (man == 10'd0) r = {s, 31'd0};
      else r = {s, bexp, norm[9:0], 13'd0};
    end else if (ex == 5'h1f) begin
      r = {s, 8'hff, man, 13'd0};
    end else begin
      r = {s, 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
    return r;
  endfunction

  function automatic logic [15:0] single_to_half(input logic [31:0] w);
    logic        s;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] full;
    logic [4:0]  sh;
    logic [47:0] ext;
    logic [23:0] q;
    logic        g;
    logic        st;
    logic [10:0] sub;
    logic [10:0] nm;
    logic [15:0] r;
    s    = w[31];
    ex   = w[30:23];
    man  = w[22:0];
    full = {1'b1, man};
    sh   = 5'(8'd126 - ex);
    ext  = {full, 24'd0} >> sh;
    q    = ext[47:24];
    g    = ext[23];
    st   = |ext[22:0];
    sub  = 11'(q) + 11'(g & (st | q[0]));
    nm   = 11'({man[22:13]}) + 11'(man[12] & ((|man[11:0]) | man[13]));
    if (ex == 8'hff) begin
      r = {s, (man != 23'd0) ? HALF_QNAN[14:0] : HALF_INF[14:0]};
    end else if (ex >= 8'd143) begin
      r = {s, HALF_INF[14:0]};
    end else if (ex <= 8'd112) begin
      if (ex < 8'd102) r = {s, 15'd0};
      else r = {s, 4'd0, sub};
    end else if (nm[10]) begin
      if (ex == 8'd142) r = {s, HALF_INF[14:0]};
      else r = {s, 5'(ex - 8'd111), 10'd0};
    end else begin
      r = {s, 5'(ex - 8'd112), nm[9:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/hsfc_if.sv =====
// valid/ready channel interface carrying a generic payload
interface hsfc_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/hsfc_core.sv =====
// combinational conversion datapath
module hsfc_core import hsfc_pkg::*; (
  input  logic        opcode,
  input  logic [31:0] operand_bits,
  output logic [31:0] result_bits
);
  always_comb begin
    if (op_t'(opcode) == OP_H2S) result_bits = half_to_single(operand_bits[15:0]);
    else result_bits = {16'd0, single_to_half(operand_bits)};
  end
endmodule

// ===== rtl/half_single_float_converter.sv =====
// top level: registered half/single converter
// usage:
//   in  channel: request payload {opcode, operand_bits}; opcode 0 converts
//   binary16 (low 16 bits) to binary32, opcode 1 converts binary32 to
//   binary16 with round to nearest even
//   out channel: result_bits, half results zero-extended
//   path: an accepted request goes to the input register, and its conversion
//   is loaded into the result register when that register can advance
//   throughput: one request per cycle while the receiver is not stalling,
//   set by the combinational conversion logic between the input and result registers
//   stall: a stalled receiver holds the result register; the input register
//   advances only when the result register is empty or being drained,
//   so no request is lost or duplicated
//   reset: rst synchronous active high clears both valid flags
module half_single_float_converter import hsfc_pkg::*; (
  input logic clk,
  input logic rst,
  hsfc_if.sink   in_ch,
  hsfc_if.source out_ch
);
  logic        in_valid;
  logic        in_op;
  logic [31:0] in_bits;
  logic [31:0] conv;
  logic        out_valid;
  logic [31:0] out_bits;
  logic        adv;

  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = !in_valid || adv;

  hsfc_core u_core (.opcode(in_op), .operand_bits(in_bits), .result_bits(conv));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid <= in_ch.valid;
      if (adv) out_valid <= in_valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_op   <= in_ch.payload.opcode;
      in_bits <= in_ch.payload.operand_bits;
    end
    if (adv && in_valid) out_bits <= conv;
  end

  assign out_ch.valid               = out_valid;
  assign out_ch.payload.result_bits = out_bits;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_bits))
    else $error("result changed under stall");
  a_move: assert property (@(posedge clk) disable iff (rst)
    in_valid && adv |=> out_valid)
    else $error("request dropped");
  a_zext: assert property (@(posedge clk) disable iff (rst)
    in_valid && adv && in_op |=> out_bits[31:16] == 16'd0)
    else $error("half result not zero-extended");
`endif
endmodule

// ===== test/half_single_float_converter_checker.sv =====
// checker: predicts each conversion and compares results in order
`timescale 1ns / 1ps
module half_single_float_converter_checker import hsfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [32:0] req_payload,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [31:0] res_payload,
  output int          errors,
  output int          pending,
  output int          widen_count,
  output int          narrow_count
);

  logic [31:0] expected_q[$];

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [10:0] man;
    logic [7:0]  bexp;
    sgn = {h[15], 31'd0};
    ex  = h[14:10];
    man = {1'b0, h[9:0]};
    if (ex == 5'd0) begin
      if (man == 11'd0) return sgn;
      bexp = 8'd113;
      while (!man[10]) begin
        man  = man << 1;
        bexp = bexp - 8'd1;
      end
      return sgn | {1'b0, bexp, man[9:0], 13'd0};
    end
    if (ex == 5'h1f) return sgn | 32'h7f800000 | {9'd0, man[9:0], 13'd0};
    return sgn | {1'b0, 8'(ex + 8'd112), man[9:0], 13'd0};
  endfunction

  function automatic logic [15:0] narrow_single(input logic [31:0] w);
    logic [15:0] sgn;
    logic [31:0] man;
    logic [31:0] rnd;
    int          hexp;
    int          sh;
    sgn  = {w[31], 15'd0};
    man  = {9'd0, w[22:0]};
    if (w[30:23] == 8'hff) return sgn | (man != 0 ? HALF_QNAN : HALF_INF);
    hexp = int'(w[30:23]) - 127 + 15;
    if (hexp >= 31) return sgn | HALF_INF;
    if (hexp <= 0) begin
      if (hexp < -10) return sgn;
      man = man | 32'h800000;
      sh  = 14 - hexp;
      rnd = man + ((32'd1 << (sh - 1)) - 32'd1) + ((man >> sh) & 32'd1);
      return sgn | 16'(rnd >> sh);
    end
    rnd = man + 32'h0fff + ((man >> 13) & 32'd1);
    if (rnd[23]) begin
      rnd  = 0;
      hexp = hexp + 1;
      if (hexp >= 31) return sgn | HALF_INF;
    end
    return sgn | 16'(hexp << 10) | 16'(rnd >> 13);
  endfunction

  assign pending = expected_q.size();

  initial begin
    errors       = 0;
    widen_count  = 0;
    narrow_count = 0;
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        if (op_t'(req_payload[32]) == OP_H2S) begin
          expected_q.push_back(widen_half(req_payload[15:0]));
          widen_count++;
        end else begin
          expected_q.push_back({16'd0, narrow_single(req_payload[31:0])});
          narrow_count++;
        end
      end
      if (res_valid && res_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res_payload);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (want !== res_payload) begin
            $display("%0t: result_bits expected %h actual %h", $time, want, res_payload);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== test/half_single_float_converter_tb.sv =====
// testbench top: stimulus, result stalls, timeout and verdict
`timescale 1ns / 1ps
module half_single_float_converter_tb import hsfc_pkg::*;;
  logic clk;
  logic rst;
  logic calm;
  int   errors;
  int   pending;
  int   widen_count;
  int   narrow_count;
  int   cycles;
  int   stall_left;

  hsfc_if #(.payload_t(req_t)) in_ch (clk);
  hsfc_if #(.payload_t(res_t)) out_ch (clk);

  half_single_float_converter DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  half_single_float_converter_checker checker_inst (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (in_ch.valid),
    .req_ready    (in_ch.ready),
    .req_payload  (in_ch.payload),
    .res_valid    (out_ch.valid),
    .res_ready    (out_ch.ready),
    .res_payload  (out_ch.payload),
    .errors       (errors),
    .pending      (pending),
    .widen_count  (widen_count),
    .narrow_count (narrow_count)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    rst           = 1'b1;
    calm          = 1'b0;
    stall_left    = 0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
  end

  // result-side stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (calm || $urandom_range(0, 5) != 0) begin
      out_ch.ready <= 1'b1;
    end else begin
      stall_left   <= $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(input op_t op, input logic [31:0] bits);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= {op, bits};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [31:0] random_single();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 5))
      0: w[30:23] = 8'($urandom_range(100, 145));
      1: w[30:23] = 8'($urandom_range(111, 143));
      2: w[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      3: begin
        w[30:23] = 8'($urandom_range(101, 143));
        w[12:0]  = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff;
      end
      4: begin
        w[30:23] = 8'($urandom_range(101, 142));
        w[22:13] = 10'h3ff;
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic [31:0] directed_single[$];
    logic [31:0] directed_half[$];
    cycles = 0;
    directed_half = '{32'h0000, 32'h8000, 32'h0001, 32'h03ff, 32'h0200, 32'h0400,
                      32'h7bff, 32'h7c00, 32'hfc00, 32'h7c01, 32'h7e00,
                      32'hffff_3c00};
    directed_single = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7f80_0000,
                        32'hff80_0000, 32'h7f80_0001, 32'hffc0_0000, 32'h477f_f000,
                        32'h4780_0000, 32'h3880_0000, 32'h387f_f000, 32'h3300_0000,
                        32'h3300_0001, 32'h3f80_1000, 32'h3f80_3000, 32'h3380_0000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_half[i]) send_request(OP_H2S, directed_half[i]);
    foreach (directed_single[i]) send_request(OP_S2H, directed_single[i]);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1350; n++) begin
      if (n == 1150) calm = 1'b1;
      if ($urandom_range(0, 1) == 0) send_request(OP_H2S, $urandom());
      else send_request(OP_S2H, random_single());
    end
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d half-to-single and %0d single-to-half conversions", widen_count,
             narrow_count);
    $display("including zeros, subnormals, rounding ties, overflow, infinities and NaNs");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hsfc_pkg.sv
rtl/hsfc_if.sv
rtl/hsfc_core.sv
rtl/half_single_float_converter.sv
test/half_single_float_converter_checker.sv
test/half_single_float_converter_tb.sv
